// ===== rtl/capped_mean_variance_update_defines.svh =====
// assertion macros shared by the capped mean and variance update block
`ifndef CAPPED_MEAN_VARIANCE_UPDATE_DEFINES_SVH
`define CAPPED_MEAN_VARIANCE_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CMVU_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
`define CMVU_ASSERT(label, prop) `CMVU_ASSERT_CLK(label, clock, reset, prop)
`else
`define CMVU_ASSERT_CLK(label, clk, rst, prop)
`define CMVU_ASSERT(label, prop)
`endif

`endif

// ===== rtl/cmvu_pkg.sv =====
// shared types and constants for the capped mean and variance update block
`timescale 1ns / 1ps

package cmvu_pkg;

   localparam int INV_CAP_W = 24;
   localparam int CAP_FRAC  = 16;
   localparam logic [INV_CAP_W-1:0] INV_CAP_RESET = 24'd65536;

   typedef struct packed {
      logic valid;
      logic last;
   } cmvu_ctl_type;

endpackage

// ===== rtl/cmvu_root_step.sv =====
// one restoring digit step of the pipelined square root, registered
`timescale 1ns / 1ps

module cmvu_root_step
   import cmvu_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int STEP       = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  cmvu_ctl_type                 src_ctl,
   input  logic [4*WORD_WIDTH-1:0]      src_pay,
   input  logic [(WORD_WIDTH+FRAC_BITS+1)/2+1:0] src_rem,
   input  logic [(WORD_WIDTH+FRAC_BITS+1)/2-1:0] src_root,
   output cmvu_ctl_type                 dst_ctl,
   output logic [4*WORD_WIDTH-1:0]      dst_pay,
   output logic [(WORD_WIDTH+FRAC_BITS+1)/2+1:0] dst_rem,
   output logic [(WORD_WIDTH+FRAC_BITS+1)/2-1:0] dst_root
);

   localparam int NSTEP = (WORD_WIDTH + FRAC_BITS + 1) / 2;
   localparam int TOT   = 2 * NSTEP;
   localparam int RMW   = NSTEP + 2;

   logic [TOT-1:0]   rad;
   logic [1:0]       pair;
   logic [RMW-1:0]   shifted;
   logic [RMW-1:0]   trial;
   logic             ge;
   logic [RMW-1:0]   rem_in;
   logic [NSTEP-1:0] root_in;

   cmvu_ctl_type             ctl_ff;
   logic [4*WORD_WIDTH-1:0]  pay_ff;
   logic [RMW-1:0]           rem_ff;
   logic [NSTEP-1:0]         root_ff;

   always_comb begin
      rad     = TOT'({src_pay[2*WORD_WIDTH-1:WORD_WIDTH], {FRAC_BITS{1'b0}}});
      pair    = rad[TOT-1-2*STEP -: 2];
      shifted = {src_rem[RMW-3:0], pair};
      trial   = {src_root, 2'b01};
      ge      = (shifted >= trial);
      rem_in  = ge ? (shifted - trial) : shifted;
      root_in = {src_root[NSTEP-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= src_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff  <= src_pay;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dst_ctl  = ctl_ff;
   assign dst_pay  = pay_ff;
   assign dst_rem  = rem_ff;
   assign dst_root = root_ff;

endmodule

// ===== rtl/cmvu_cap_mult.sv =====
// cap stage: square root times the reciprocal cap factor, registered
`timescale 1ns / 1ps

module cmvu_cap_mult
   import cmvu_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  cmvu_ctl_type                 src_ctl,
   input  logic [4*WORD_WIDTH-1:0]      src_pay,
   input  logic [(WORD_WIDTH+FRAC_BITS+1)/2-1:0] src_root,
   input  logic [INV_CAP_W-1:0]         inverse_cap,
   output cmvu_ctl_type                 dst_ctl,
   output logic [4*WORD_WIDTH-1:0]      dst_pay,
   output logic [(WORD_WIDTH+FRAC_BITS+1)/2+INV_CAP_W-CAP_FRAC-1:0] dst_cap
);

   localparam int NSTEP = (WORD_WIDTH + FRAC_BITS + 1) / 2;
   localparam int PRODW = NSTEP + INV_CAP_W;
   localparam int CAPW  = PRODW - CAP_FRAC;

   logic [PRODW-1:0] prod;
   logic [CAPW-1:0]  cap_in;

   cmvu_ctl_type            ctl_ff;
   logic [4*WORD_WIDTH-1:0] pay_ff;
   logic [CAPW-1:0]         cap_ff;

   always_comb begin
      prod   = PRODW'(src_root) * PRODW'(inverse_cap);
      cap_in = prod[PRODW-1:CAP_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= src_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff <= src_pay;
         cap_ff <= cap_in;
      end
   end

   assign dst_ctl = ctl_ff;
   assign dst_pay = pay_ff;
   assign dst_cap = cap_ff;

endmodule

// ===== rtl/cmvu_limit.sv =====
// limit stage: clips the magnitude of both deltas to the cap, keeping the sign
`timescale 1ns / 1ps

module cmvu_limit
   import cmvu_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  cmvu_ctl_type                 src_ctl,
   input  logic [4*WORD_WIDTH-1:0]      src_pay,
   input  logic [(WORD_WIDTH+FRAC_BITS+1)/2+INV_CAP_W-CAP_FRAC-1:0] src_cap,
   output cmvu_ctl_type                 dst_ctl,
   output logic [WORD_WIDTH-1:0]        dst_mean,
   output logic [WORD_WIDTH-1:0]        dst_var,
   output logic [WORD_WIDTH:0]          dst_dm,
   output logic [WORD_WIDTH:0]          dst_dv
);

   localparam int W     = WORD_WIDTH;
   localparam int NSTEP = (WORD_WIDTH + FRAC_BITS + 1) / 2;
   localparam int CAPW  = NSTEP + INV_CAP_W - CAP_FRAC;
   localparam int CMPW  = (W > CAPW) ? W : CAPW;

   function automatic logic [W:0] limit_delta(input logic [W-1:0] d,
                                              input logic [CAPW-1:0] cap);
      logic            neg;
      logic [W-1:0]    mag;
      logic [CMPW-1:0] magx;
      logic [CMPW-1:0] capx;
      logic [CMPW-1:0] limx;
      logic [W:0]      lim;
      neg  = d[W-1];
      mag  = neg ? (~d + 1'b1) : d;
      magx = CMPW'(mag);
      capx = CMPW'(cap);
      limx = (magx > capx) ? capx : magx;
      lim  = {1'b0, limx[W-1:0]};
      return neg ? (~lim + 1'b1) : lim;
   endfunction

   logic [W:0] dm_in;
   logic [W:0] dv_in;

   cmvu_ctl_type ctl_ff;
   logic [W-1:0] mean_ff;
   logic [W-1:0] var_ff;
   logic [W:0]   dm_ff;
   logic [W:0]   dv_ff;

   always_comb begin
      dm_in = limit_delta(src_pay[3*W-1:2*W], src_cap);
      dv_in = limit_delta(src_pay[4*W-1:3*W], src_cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= src_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mean_ff <= src_pay[W-1:0];
         var_ff  <= src_pay[2*W-1:W];
         dm_ff   <= dm_in;
         dv_ff   <= dv_in;
      end
   end

   assign dst_ctl  = ctl_ff;
   assign dst_mean = mean_ff;
   assign dst_var  = var_ff;
   assign dst_dm   = dm_ff;
   assign dst_dv   = dv_ff;

endmodule

// ===== rtl/cmvu_apply.sv =====
// apply stage: adds the limited deltas and saturates, feeds the result register
`timescale 1ns / 1ps

module cmvu_apply
   import cmvu_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cmvu_ctl_type          src_ctl,
   input  logic [WORD_WIDTH-1:0] src_mean,
   input  logic [WORD_WIDTH-1:0] src_var,
   input  logic [WORD_WIDTH:0]   src_dm,
   input  logic [WORD_WIDTH:0]   src_dv,
   output cmvu_ctl_type          dst_ctl,
   output logic [WORD_WIDTH-1:0] dst_mean,
   output logic [WORD_WIDTH-1:0] dst_var
);

   localparam int W = WORD_WIDTH;
   localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};

   logic signed [W+1:0] sum_m;
   logic signed [W+1:0] sum_v;
   logic [W-1:0]        mean_in;
   logic [W-1:0]        var_in;

   cmvu_ctl_type ctl_ff;
   logic [W-1:0] mean_ff;
   logic [W-1:0] var_ff;

   always_comb begin
      sum_m = $signed({{2{src_mean[W-1]}}, src_mean}) + $signed({src_dm[W], src_dm});
      sum_v = $signed({2'b00, src_var}) + $signed({src_dv[W], src_dv});
      priority if (sum_m > SMAX) begin
         mean_in = SMAX[W-1:0];
      end else if (sum_m < SMIN) begin
         mean_in = SMIN[W-1:0];
      end else begin
         mean_in = sum_m[W-1:0];
      end
      priority if (sum_v[W+1]) begin
         var_in = '0;
      end else if (sum_v[W]) begin
         var_in = '1;
      end else begin
         var_in = sum_v[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= src_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mean_ff <= mean_in;
         var_ff  <= var_in;
      end
   end

   assign dst_ctl  = ctl_ff;
   assign dst_mean = mean_ff;
   assign dst_var  = var_ff;

endmodule

// ===== rtl/capped_mean_variance_update.sv =====
// Capped mean and variance update. Each transaction carries one parameter's
// mean, variance and proposed deltas; both deltas are limited in magnitude to
// floor(sqrt(variance) * inverse_cap) and added, the mean saturating to the
// signed range and the variance clamping to [0, 2^WORD_WIDTH - 1]. One
// transaction is taken every cycle while no result waits on rsp_tready;
// the whole pipeline holds while a result waits. There are
// (WORD_WIDTH + FRAC_BITS + 1) / 2 square root digit stages plus multiply,
// limit and apply stages. inverse_cap resets to 1.0 (Q8.16); csr_ writes it.
`timescale 1ns / 1ps
`include "capped_mean_variance_update_defines.svh"

module capped_mean_variance_update
   import cmvu_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [INV_CAP_W-1:0]                 csr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // mean_in, variance_in, delta_mean, delta_variance, zero fill
   input  logic [((4*WORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // mean_out, variance_out, zero fill
   output logic [((2*WORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   output logic                                 rsp_tlast
);

   localparam int W     = WORD_WIDTH;
   localparam int NSTEP = (WORD_WIDTH + FRAC_BITS + 1) / 2;
   localparam int TOT   = 2 * NSTEP;
   localparam int RMW   = NSTEP + 2;
   localparam int CAPW  = NSTEP + INV_CAP_W - CAP_FRAC;
   localparam int OUT_W = ((2*W + 7) / 8) * 8;
   localparam int RSQ_W = TOT + 2;

   logic                 adv;
   logic [INV_CAP_W-1:0] inverse_cap_ff;

   cmvu_ctl_type     ctl_s  [0:NSTEP];
   logic [4*W-1:0]   pay_s  [0:NSTEP];
   logic [RMW-1:0]   rem_s  [0:NSTEP];
   logic [NSTEP-1:0] root_s [0:NSTEP];

   cmvu_ctl_type   ctl_cap;
   logic [4*W-1:0] pay_cap;
   logic [CAPW-1:0] cap;

   cmvu_ctl_type ctl_lim;
   logic [W-1:0] mean_lim;
   logic [W-1:0] var_lim;
   logic [W:0]   dm_lim;
   logic [W:0]   dv_lim;

   cmvu_ctl_type ctl_out;
   logic [W-1:0] mean_out;
   logic [W-1:0] var_out;

   logic [TOT-1:0] final_rad;

   assign adv        = rsp_tready | ~rsp_tvalid;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_cap_ff <= INV_CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         inverse_cap_ff <= csr_data;
      end
   end

   assign ctl_s[0]  = '{valid: req_tvalid, last: req_tlast};
   assign pay_s[0]  = req_tdata[4*W-1:0];
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;

   for (genvar g = 0; g < NSTEP; g++) begin : g_root
      cmvu_root_step #(
         .WORD_WIDTH(WORD_WIDTH),
         .FRAC_BITS (FRAC_BITS),
         .STEP      (g)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .src_ctl (ctl_s[g]),
         .src_pay (pay_s[g]),
         .src_rem (rem_s[g]),
         .src_root(root_s[g]),
         .dst_ctl (ctl_s[g+1]),
         .dst_pay (pay_s[g+1]),
         .dst_rem (rem_s[g+1]),
         .dst_root(root_s[g+1])
      );
   end

   cmvu_cap_mult #(
      .WORD_WIDTH(WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_cap (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .src_ctl    (ctl_s[NSTEP]),
      .src_pay    (pay_s[NSTEP]),
      .src_root   (root_s[NSTEP]),
      .inverse_cap(inverse_cap_ff),
      .dst_ctl    (ctl_cap),
      .dst_pay    (pay_cap),
      .dst_cap    (cap)
   );

   cmvu_limit #(
      .WORD_WIDTH(WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_limit (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .src_ctl (ctl_cap),
      .src_pay (pay_cap),
      .src_cap (cap),
      .dst_ctl (ctl_lim),
      .dst_mean(mean_lim),
      .dst_var (var_lim),
      .dst_dm  (dm_lim),
      .dst_dv  (dv_lim)
   );

   cmvu_apply #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_apply (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .src_ctl (ctl_lim),
      .src_mean(mean_lim),
      .src_var (var_lim),
      .src_dm  (dm_lim),
      .src_dv  (dv_lim),
      .dst_ctl (ctl_out),
      .dst_mean(mean_out),
      .dst_var (var_out)
   );

   assign rsp_tvalid = ctl_out.valid;
   assign rsp_tlast  = ctl_out.last;
   assign rsp_tdata  = OUT_W'({var_out, mean_out});

   assign final_rad = TOT'({pay_s[NSTEP][2*W-1:W], {FRAC_BITS{1'b0}}});

   // root leaving the digit pipeline is the floor of the square root
   `CMVU_ASSERT(a_root_not_high,
      ctl_s[NSTEP].valid |-> (RSQ_W'(root_s[NSTEP]) * RSQ_W'(root_s[NSTEP]) <= RSQ_W'(final_rad)))
   `CMVU_ASSERT(a_root_not_low,
      ctl_s[NSTEP].valid |-> ((RSQ_W'(root_s[NSTEP]) + 1'b1) * (RSQ_W'(root_s[NSTEP]) + 1'b1) > RSQ_W'(final_rad)))
   `CMVU_ASSERT(a_csr_write,
      (csr_valid && csr_ready) |=> (inverse_cap_ff == $past(csr_data)))

endmodule
